// ----- sv/frame_crc8_crc16_engine_macros.svh -----
// Assertion macros used by the checker file.
`ifndef FRAME_CRC8_CRC16_ENGINE_MACROS_SVH
`define FRAME_CRC8_CRC16_ENGINE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define FCRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lbl failed");

// Next-cycle implication, disabled in reset.
`define FCRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lbl failed");

`endif

// ----- sv/fcrc_pkg.sv -----
// Types, constants and the CRC byte update for the frame CRC engine.
package fcrc_pkg;

	localparam logic [7:0]  CRC8_INIT  = 8'hFF;
	localparam logic [7:0]  CRC8_POLY  = 8'h8C;
	localparam logic [15:0] CRC16_INIT = 16'hFFFF;
	localparam logic [15:0] CRC16_POLY = 16'h8408;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_CRC_KIND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_OP = 2'd1;

	localparam logic [1:0] OP_COMPUTE = 2'd0;
	localparam logic [1:0] OP_VERIFY  = 2'd1;
	localparam logic [1:0] OP_APPEND  = 2'd2;

	localparam logic KIND_CRC8  = 1'b0;
	localparam logic KIND_CRC16 = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_is_crc;
		logic [15:0] crc_value;
		logic        check_ok;
		logic        frame_done;
		logic        run_last;
	} out_word_t;

	// All results caused by one input word, in compact form.
	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] crc;
		logic        ok;
		logic        done;
		logic [1:0]  cnt;     // number of result words, 1 to 3
	} grp_t;

	function automatic logic [15:0] init_value(input logic kind);
		return (kind == KIND_CRC16) ? CRC16_INIT : {8'h00, CRC8_INIT};
	endfunction

	// Reflected CRC update by one byte, LSB first.
	function automatic logic [15:0] crc_absorb(input logic [15:0] crc_in,
		input logic [7:0] b, input logic kind);
		logic [15:0] c;
		logic [15:0] poly;
		poly = (kind == KIND_CRC16) ? CRC16_POLY : {8'h00, CRC8_POLY};
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
		end
		return (kind == KIND_CRC16) ? c : {8'h00, c[7:0]};
	endfunction

endpackage

// ----- sv/fcrc_core.sv -----
// Frame state and per-word CRC logic: turns one input word into a result group.
module fcrc_core
	import fcrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 take,
	input  in_word_t             in_word,
	output grp_t                 grp
);

	logic        kind_q;
	logic [1:0]  op_q;
	logic [15:0] crc_q;
	logic [7:0]  held_q [2];
	logic [1:0]  seen_q;

	logic        is_verify;
	logic        absorb_now;
	logic [7:0]  verify_byte;
	logic [15:0] crc_next;
	logic [15:0] expect_crc;
	logic        ok;
	logic [1:0]  seen_next;

	assign is_verify = (op_q == OP_VERIFY);

	// Verify mode delays coverage by the CRC length.
	assign absorb_now  = (kind_q == KIND_CRC16) ? (seen_q >= 2'd2) : (seen_q >= 2'd1);
	assign verify_byte = (kind_q == KIND_CRC16) ? held_q[1] : held_q[0];
	assign seen_next   = (seen_q == 2'd2) ? seen_q : seen_q + 2'd1;
	assign expect_crc  = (kind_q == KIND_CRC16) ? {in_word.data_byte, held_q[0]}
		: {8'h00, in_word.data_byte};

	always_comb begin
		if (is_verify) begin
			crc_next = absorb_now ? crc_absorb(crc_q, verify_byte, kind_q) : crc_q;
		end else begin
			crc_next = crc_absorb(crc_q, in_word.data_byte, kind_q);
		end
	end

	// A one-byte CRC-16 frame has no full trailer and fails.
	assign ok = is_verify && in_word.frame_last && (crc_next == expect_crc)
		&& ((kind_q == KIND_CRC8) || (seen_q >= 2'd1));

	always_comb begin
		grp.data_byte = in_word.data_byte;
		grp.crc       = crc_next;
		grp.ok        = ok;
		grp.done      = in_word.frame_last;
		if ((op_q == OP_APPEND) && in_word.frame_last) begin
			grp.cnt = (kind_q == KIND_CRC16) ? 2'd3 : 2'd2;
		end else begin
			grp.cnt = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= KIND_CRC8;
			op_q      <= OP_COMPUTE;
			crc_q     <= init_value(KIND_CRC8);
			held_q[0] <= '0;
			held_q[1] <= '0;
			seen_q    <= '0;
		end else if (cfg_valid && ((cfg_index == REG_CRC_KIND)
			|| (cfg_index == REG_FRAME_OP))) begin
			// any register write restarts the frame
			if (cfg_index == REG_CRC_KIND) begin
				kind_q <= cfg_data[0];
				crc_q  <= init_value(cfg_data[0]);
			end else begin
				op_q  <= cfg_data;
				crc_q <= init_value(kind_q);
			end
			held_q[0] <= '0;
			held_q[1] <= '0;
			seen_q    <= '0;
		end else if (take) begin
			if (in_word.frame_last) begin
				crc_q     <= init_value(kind_q);
				held_q[0] <= '0;
				held_q[1] <= '0;
				seen_q    <= '0;
			end else begin
				crc_q <= crc_next;
				if (is_verify) begin
					held_q[1] <= held_q[0];
					held_q[0] <= in_word.data_byte;
					seen_q    <= seen_next;
				end
			end
		end
	end

endmodule

// ----- sv/fcrc_oseq.sv -----
// Result register: holds one result group and sends its words one per cycle while out_ready is high.
module fcrc_oseq
	import fcrc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  grp_t      grp_d,
	output logic      free,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_word
);

	logic       valid_q;
	logic [1:0] idx_q;
	grp_t       grp_q;
	logic       last_beat;
	logic       two_only;

	assign last_beat = (idx_q == (grp_q.cnt - 2'd1));
	assign free      = !valid_q || (out_ready && last_beat);
	assign out_valid = valid_q;
	assign two_only  = (grp_q.cnt == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (take) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && out_ready) begin
			if (last_beat) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			grp_q <= grp_d;
		end
	end

	always_comb begin
		out_word.crc_value = grp_q.crc;
		out_word.check_ok  = 1'b0;
		unique case (idx_q)
			2'd0: begin
				out_word.out_byte   = grp_q.data_byte;
				out_word.out_is_crc = 1'b0;
				out_word.check_ok   = (grp_q.cnt == 2'd1) && grp_q.ok;
				out_word.frame_done = (grp_q.cnt == 2'd1) && grp_q.done;
				out_word.run_last   = (grp_q.cnt == 2'd1);
			end
			2'd1: begin
				out_word.out_byte   = grp_q.crc[7:0];
				out_word.out_is_crc = 1'b1;
				out_word.frame_done = two_only;
				out_word.run_last   = two_only;
			end
			2'd2: begin
				out_word.out_byte   = grp_q.crc[15:8];
				out_word.out_is_crc = 1'b1;
				out_word.frame_done = 1'b1;
				out_word.run_last   = 1'b1;
			end
			default: begin
				out_word.out_byte   = grp_q.data_byte;
				out_word.out_is_crc = 1'b0;
				out_word.frame_done = 1'b0;
				out_word.run_last   = 1'b1;
			end
		endcase
	end

endmodule

// ----- sv/frame_crc8_crc16_engine.sv -----
// Top level of the frame CRC engine: core logic plus output result register.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_word) takes one frame byte per word,
//    frame_last marks the final byte of a frame.
//  - Output channel (out_valid/out_ready/out_word) gives result words.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes crc_kind
//    (index 0) and frame_op (index 1); cfg_ready is always high. Any write
//    restarts the frame; indexes above 1 are ignored. Write only while idle.
//  - Output: the first result word is registered and appears in the cycle after its input word is taken.
//  - Throughput: one input word per cycle while out_ready is high. Compute and
//    verify give one result word per input; append gives 2 (CRC-8) or 3 (CRC-16)
//    words on the last byte and holds in_ready low until the last CRC word is sent.
//    The rate is set by the single result register draining one word per cycle.
//  - Reset: CRC-8, compute mode, CRC at 0xFF, no result pending.
//  - Stall: while out_ready is low the current result word holds and
//    in_ready stays low once the result register is full.
module frame_crc8_crc16_engine
	import fcrc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_word_t             in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_word_t            out_word,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	logic take;    // input word accepted this cycle
	logic free;    // result register can load a new group
	grp_t grp;     // all results of the current input word

	assign cfg_ready = 1'b1;
	assign in_ready  = free;
	assign take      = in_valid && free;

	// CRC state, held trailer bytes and config registers
	fcrc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.in_word   (in_word),
		.grp       (grp)
	);

	// result register, unrolls append groups into single words
	fcrc_oseq u_oseq (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.grp_d     (grp),
		.free      (free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

// ----- sv/fcrc_checker.sv -----
// Port-level checker for the frame CRC engine, bound to the top level.
`include "frame_crc8_crc16_engine_macros.svh"

module fcrc_checker
	import fcrc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_word
);

	// stalled result word holds
	`FCRC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word))

	// a word that is not the last of its run is followed at once by the next
	`FCRC_ASSERT_NEXT(a_run_cont, clk, arst_n, out_valid && out_ready && !out_word.run_last, out_valid)

	// frame close is always the last word of its run
	`FCRC_ASSERT_IMPL(a_done_last, clk, arst_n, out_valid && out_word.frame_done, out_word.run_last)

	// appended CRC words never carry a check result and match crc_value
	`FCRC_ASSERT_IMPL(a_crc_word, clk, arst_n, out_valid && out_word.out_is_crc, !out_word.check_ok && ((out_word.out_byte == out_word.crc_value[7:0]) || (out_word.out_byte == out_word.crc_value[15:8])))

endmodule

bind frame_crc8_crc16_engine fcrc_checker u_fcrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);
